FILE: src/rmf_pkg.sv
// Shared types and constants for the RGB matrix frame store.
// Holds the transaction structs, command codes and packet opcodes.
// No dependencies.
`timescale 1ns / 1ps

package rmf_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
  localparam logic [2:0] CMD_FILL      = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_DRAW_BITS = 3'd3;
  localparam logic [2:0] CMD_SHOW      = 3'd4;

  // Packet opcodes, first byte of every packet
  localparam logic [7:0] OP_SET_FRAME = 8'h02;
  localparam logic [7:0] OP_CLEAR     = 8'h20;
  localparam logic [7:0] OP_FILL      = 8'h21;

  // Leftmost pixel of a bitmap byte
  localparam logic [7:0] BIT_LEFT = 8'h80;

  // Largest number of bits drawn from one bitmap byte
  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] x_position;
    logic [7:0] y_position;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] bit_row;
    logic [3:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] packet_bytes;
    logic [3:0]  byte_count;
    logic        last_chunk;
    logic [6:0]  target_address;
  } out_item_t;

  // One packet byte handed from the sequencer to the chunk packer
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       last;
  } byte_push_t;

endpackage

FILE: src/rmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the pixel store. No dependencies.
`timescale 1ns / 1ps

module rmf_ram #(
  parameter int DATA_WIDTH = 24,
  parameter int DEPTH      = 128,
  parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_WIDTH-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_WIDTH-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/rmf_packer.sv
// Chunk packer: gathers packet bytes one at a time into chunks of up to
// eight bytes and holds each finished chunk in the output register.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  rmf_pkg::byte_push_t push,
  output logic               push_rdy,
  input  logic [6:0]         target_address,
  output logic               out_valid,
  input  logic               out_stall,
  output rmf_pkg::out_item_t out_data
);

  import rmf_pkg::*;

  logic [63:0] chunk_r;
  logic [2:0]  cnt_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        completes;
  logic        out_free;
  logic [63:0] merged;

  // A byte that closes a chunk needs a free output register
  assign completes = push.last || (cnt_r == 3'd7);
  assign out_free  = !out_valid_r || !out_stall;
  assign push_rdy  = !completes || out_free;

  // Insert the byte at the next free lane
  assign merged = chunk_r | ({56'b0, push.data} << {cnt_r, 3'b000});

  // Hold the chunk being built and the output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      chunk_r     <= '0;
    end else begin
      if (push.push && push_rdy) begin
        if (completes) begin
          out_data_r.packet_bytes   <= merged;
          out_data_r.byte_count     <= {1'b0, cnt_r} + 4'd1;
          out_data_r.last_chunk     <= push.last;
          out_data_r.target_address <= target_address;
          out_valid_r               <= 1'b1;
          cnt_r                     <= 3'd0;
          chunk_r                   <= '0;
        end else begin
          chunk_r <= merged;
          cnt_r   <= cnt_r + 3'd1;
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_chunk |-> out_data_r.byte_count == 4'd8)
    else $error("non-final chunk is not full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.byte_count != 4'd0 && out_data_r.byte_count <= 4'd8)
    else $error("chunk byte count out of range");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.push && push_rdy && push.last |=> cnt_r == 3'd0 && chunk_r == '0)
    else $error("packer not emptied after final byte");
`endif

endmodule

FILE: src/rgb_matrix_framebuffer.sv
// RGB matrix frame store. Set-pixel writes one pixel if it is in range; draw-bits
// walks min(bit_count, 8) bits of the bitmap row, leftmost first, along the row.
// Fill and clear: after dispatch, one store write a cycle over all
// MATRIX_WIDTH*MATRIX_HEIGHT addresses, then one header byte a cycle while the
// packer accepts it. Show: after dispatch, three header bytes, then per pixel one
// store read and three bytes through the byte-wide chunk packer, which can stall.
// Synchronous active-low reset, then a clearing pass over the whole store during
// which no transaction is accepted; bus address resets to zero.
`timescale 1ns / 1ps

module rgb_matrix_framebuffer #(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rmf_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  import rmf_pkg::*;

  localparam int PIXELS = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [AW-1:0] ADDR_ONE  = AW'(1);
  localparam logic [8:0]    COL_LIMIT = 9'(MATRIX_WIDTH);
  localparam logic [8:0]    ROW_LIMIT = 9'(MATRIX_HEIGHT);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_DRAW,
    S_HDR,
    S_RD,
    S_PIX
  } state_t;

  state_t        state_r;
  logic [6:0]    bus_address_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] pix_r;
  logic [23:0]   colour_r;
  logic [7:0]    col_r;
  logic [7:0]    y_r;
  logic [7:0]    bits_r;
  logic [3:0]    rem_r;
  logic [2:0]    hdr_r;
  logic [1:0]    comp_r;
  logic [7:0]    op_r;

  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [23:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [23:0]   ram_rd_data;
  logic          in_range;
  logic [AW-1:0] draw_addr;
  byte_push_t    push;
  logic          push_rdy;
  logic          push_ok;

  // Pixel store
  rmf_ram #(
    .DATA_WIDTH(24),
    .DEPTH     (PIXELS),
    .ADDR_WIDTH(AW)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(pix_r),
    .rd_data(ram_rd_data)
  );

  // Chunk packer and output register
  rmf_packer u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .push_rdy      (push_rdy),
    .target_address(bus_address_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  // Clip the current draw column and row, and form the store address
  assign in_range  = ({1'b0, col_r} < COL_LIMIT) && ({1'b0, y_r} < ROW_LIMIT);
  assign draw_addr = AW'(int'(y_r) * MATRIX_WIDTH + int'(col_r));
  assign push_ok   = push.push && push_rdy;
  assign in_stall  = (state_r != S_IDLE);

  // Drive store accesses and packet bytes from the current step
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = addr_r;
    ram_wr_data = colour_r;
    ram_rd_en   = 1'b0;
    push        = '0;
    case (state_r)
      S_INIT: begin
        ram_we      = 1'b1;
        ram_wr_data = '0;
      end
      S_SWEEP: begin
        ram_we = 1'b1;
      end
      S_DRAW: begin
        ram_wr_addr = draw_addr;
        ram_we      = (rem_r != 4'd0) && ((bits_r & BIT_LEFT) != 8'd0) && in_range;
      end
      S_RD: begin
        ram_rd_en = 1'b1;
      end
      S_HDR: begin
        push.push = 1'b1;
        case (hdr_r)
          3'd0:    push.data = op_r;
          3'd3:    push.data = colour_r[23:16];
          3'd4:    push.data = colour_r[15:8];
          3'd5:    push.data = colour_r[7:0];
          default: push.data = 8'd0;
        endcase
        push.last = ((op_r == OP_FILL) && (hdr_r == 3'd5)) ||
                    ((op_r == OP_CLEAR) && (hdr_r == 3'd2));
      end
      S_PIX: begin
        push.push = 1'b1;
        case (comp_r)
          2'd0:    push.data = ram_rd_data[23:16];
          2'd1:    push.data = ram_rd_data[15:8];
          default: push.data = ram_rd_data[7:0];
        endcase
        push.last = (comp_r == 2'd2) && (pix_r == LAST_ADDR);
      end
      default: begin
        push = '0;
      end
    endcase
  end

  // Sequencer: dispatch commands, sweep the store, walk draw bits and packet bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      addr_r        <= '0;
      bus_address_r <= 7'd0;
    end else begin
      if (cfg_wr_en) begin
        bus_address_r <= cfg_wr_data;
      end
      case (state_r)
        S_INIT: begin
          if (addr_r == LAST_ADDR) begin
            addr_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            addr_r <= addr_r + ADDR_ONE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            col_r    <= in_data.x_position;
            y_r      <= in_data.y_position;
            colour_r <= {in_data.green_level, in_data.blue_level, in_data.red_level};
            hdr_r    <= 3'd0;
            pix_r    <= '0;
            addr_r   <= '0;
            case (in_data.cmd)
              CMD_SET_PIXEL: begin
                bits_r  <= BIT_LEFT;
                rem_r   <= 4'd1;
                state_r <= S_DRAW;
              end
              CMD_DRAW_BITS: begin
                bits_r  <= in_data.bit_row;
                rem_r   <= (in_data.bit_count > MAX_BITS) ? MAX_BITS : in_data.bit_count;
                state_r <= S_DRAW;
              end
              CMD_FILL: begin
                op_r    <= OP_FILL;
                state_r <= S_SWEEP;
              end
              CMD_CLEAR: begin
                colour_r <= '0;
                op_r     <= OP_CLEAR;
                state_r  <= S_SWEEP;
              end
              CMD_SHOW: begin
                op_r    <= OP_SET_FRAME;
                state_r <= S_HDR;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (addr_r == LAST_ADDR) begin
            addr_r  <= '0;
            state_r <= S_HDR;
          end else begin
            addr_r <= addr_r + ADDR_ONE;
          end
        end
        S_DRAW: begin
          if (rem_r == 4'd0) begin
            state_r <= S_IDLE;
          end else begin
            rem_r  <= rem_r - 4'd1;
            bits_r <= {bits_r[6:0], 1'b0};
            col_r  <= col_r + 8'd1;
          end
        end
        S_HDR: begin
          if (push_ok) begin
            if (push.last) begin
              state_r <= S_IDLE;
            end else if ((hdr_r == 3'd2) && (op_r == OP_SET_FRAME)) begin
              state_r <= S_RD;
            end else begin
              hdr_r <= hdr_r + 3'd1;
            end
          end
        end
        S_RD: begin
          comp_r  <= 2'd0;
          state_r <= S_PIX;
        end
        S_PIX: begin
          if (push_ok) begin
            if (comp_r == 2'd2) begin
              if (pix_r == LAST_ADDR) begin
                state_r <= S_IDLE;
              end else begin
                pix_r   <= pix_r + ADDR_ONE;
                state_r <= S_RD;
              end
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR || state_r == S_RD || state_r == S_PIX) |-> !ram_we)
    else $error("store written while a packet is being sent");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd <= CMD_SHOW) |=> state_r != S_IDLE)
    else $error("accepted command did not start");

  a_draw_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAW && rem_r == 4'd0 |=> state_r == S_IDLE)
    else $error("draw did not finish after its last bit");
`endif

endmodule
